FILE: rtl/core/ecbf_pkg.sv
// shared types and constants for the bit-flip decoder
package ecbf_pkg;
  localparam int MAX_BITS   = 64;
  localparam int MAX_CHECKS = 32;
  localparam int BIT_W      = $clog2(MAX_BITS);
  localparam int ROW_W      = $clog2(MAX_CHECKS);
  localparam int CNT_W      = $clog2(MAX_CHECKS + 1);

  typedef enum logic [1:0] {
    CMD_LOAD_WORD = 2'd0,
    CMD_LOAD_ROW  = 2'd1,
    CMD_DECODE    = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_BITS      = 2'd0,
    REG_CHECKS    = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_MAX_ITER  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARITY,
    ST_COUNT,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // control from the sequencer into the cell row
  typedef struct packed {
    logic             clear;
    logic             shift;
    logic             parity_en;
  } cell_ctl_t;
endpackage

FILE: rtl/core/ecbf_if.sv
// valid/ready channel interfaces for the decoder
interface ecbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  row_index;
  logic [63:0] data_word;
  modport source (output valid, command, row_index, data_word, input ready);
  modport sink (input valid, command, row_index, data_word, output ready);
endinterface

interface ecbf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] decoded_word;
  logic        success;
  logic [15:0] flips_done;
  modport source (output valid, decoded_word, success, flips_done, input ready);
  modport sink (input valid, decoded_word, success, flips_done, output ready);
endinterface

interface ecbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/expander_code_bit_flip_decoder_unit.sv
// top level of the bit-flipping parity-check decoder
// Usage:
//   in_*  : one transaction per command. load word and load row give no
//           result; decode gives one result on out_*.
//   cfg_* : register writes, always accepted; write only while no decode
//           is in flight.
//   A decode runs rounds. Each round: m rows of parity (registered row
//   read), m rows of per-bit counting into a row of 64 cells, then the
//   cells shifting past a max/argmax tracker, then one decide step.
//   out_valid rises after flips + 1 rounds.
//   One item is worked on at a time; in_ready is low during a decode.
//   Reset clears the word, registers (64, 32, 16, 256) and control;
//   matrix rows are undefined until written.
//   While out_ready is low the result is held and no new item is taken.
module expander_code_bit_flip_decoder_unit import ecbf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ecbf_in_if.sink    in_ch,
  ecbf_out_if.source out_ch,
  ecbf_cfg_if.sink   cfg_ch
);
  logic [6:0]  bits_r;
  logic [5:0]  checks_r;
  logic [5:0]  thr_r;
  logic [15:0] maxit_r;
  logic [63:0] word_r;
  logic [MAX_BITS-1:0] mat [MAX_CHECKS];
  logic [MAX_CHECKS-1:0] status_r;
  state_t state_r, state_nxt;
  logic [ROW_W-1:0] row_r;
  logic [BIT_W:0] scan_r;
  logic [CNT_W-1:0] top_r;
  logic [BIT_W-1:0] best_r;
  logic [15:0] flips_r;
  logic [MAX_BITS-1:0] mask_r, row_q;
  logic [ROW_W:0] m_r;
  logic out_valid_r, succ_r;
  cell_ctl_t ctl;
  logic [CNT_W-1:0] head;
  logic in_acc, last_row;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign last_row = ({1'b0, row_r} == m_r - 1'b1);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= 7'd64; checks_r <= 6'd32; thr_r <= 6'd16; maxit_r <= 16'd256;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_BITS:      bits_r   <= cfg_ch.data[6:0];
        REG_CHECKS:    checks_r <= cfg_ch.data[5:0];
        REG_THRESHOLD: thr_r    <= cfg_ch.data[5:0];
        REG_MAX_ITER:  maxit_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // matrix memory, one row read per cycle
  always_ff @(posedge clk) begin
    if (in_acc && cmd_t'(in_ch.command) == CMD_LOAD_ROW) mat[in_ch.row_index] <= in_ch.data_word;
    row_q <= mat[row_r];
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  logic last_scan, stop;
  assign last_scan = (scan_r == (BIT_W+1)'(MAX_BITS - 1));
  assign stop = (top_r == '0) || (top_r < thr_r) || (flips_r >= maxit_r);

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    case (state_r)
      ST_IDLE:   if (in_acc && cmd_t'(in_ch.command) == CMD_DECODE) state_nxt = ST_PARITY;
      ST_PARITY: if (last_row && scan_r[0]) begin
        state_nxt = ST_COUNT; ctl.clear = 1'b1;
      end
      ST_COUNT: begin
        ctl.parity_en = scan_r[0];
        if (last_row && scan_r[0]) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        ctl.shift = 1'b1;
        if (last_scan) state_nxt = ST_OUT;
      end
      ST_OUT: state_nxt = stop ? ST_IDLE : ST_PARITY;
      default: state_nxt = ST_IDLE;
    endcase
  end

  ecbf_row u_row (.clk(clk), .ctl(ctl), .inc_vec(row_q & mask_r & {MAX_BITS{status_r[row_r]}}),
    .head_cnt(head));

  // datapath: row pointer (each row held while its registered read lands), scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0; word_r <= '0; row_r <= '0; scan_r <= '0;
      status_r <= '0; flips_r <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      if (in_acc && cmd_t'(in_ch.command) == CMD_LOAD_WORD) word_r <= in_ch.data_word;
      if (in_acc && cmd_t'(in_ch.command) == CMD_DECODE) begin
        flips_r <= '0;
        m_r <= (checks_r == 0) ? (ROW_W+1)'(1)
               : (checks_r > 6'(MAX_CHECKS)) ? (ROW_W+1)'(MAX_CHECKS)
               : checks_r[ROW_W:0];
        mask_r <= (bits_r == 0) ? 64'd1 : (bits_r >= 7'd64) ? '1
                  : ((64'd1 << bits_r) - 64'd1);
        status_r <= '0; row_r <= '0; scan_r <= '0;
      end
      case (state_r)
        ST_PARITY, ST_COUNT: begin
          if (scan_r[0]) begin
            if (state_r == ST_PARITY)
              status_r[row_r] <= ^(row_q & mask_r & word_r);
            row_r <= last_row ? '0 : row_r + 1'b1;
          end
          scan_r <= last_row && scan_r[0] ? '0 : {BIT_W'(0), ~scan_r[0]};
          top_r <= '0; best_r <= '0;
        end
        ST_DECIDE: begin
          if (head > top_r) begin top_r <= head; best_r <= scan_r[BIT_W-1:0]; end
          scan_r <= last_scan ? '0 : scan_r + 1'b1;
        end
        ST_OUT: begin
          if (stop) begin
            out_valid_r <= 1'b1; succ_r <= (top_r == '0);
          end else begin
            word_r[best_r] <= ~word_r[best_r];
            flips_r <= flips_r + 16'd1;
            status_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.decoded_word = word_r & mask_r;
  assign out_ch.success = succ_r;
  assign out_ch.flips_done = flips_r;

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("input taken during decode");
  a_flip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (flips_r <= maxit_r)) else $error("flip count past bound");
  a_success: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && succ_r) |-> (top_r == '0)) else $error("success with unsatisfied bit");
`endif
endmodule

FILE: rtl/core/ecbf_cell.sv
// one variable-bit cell: counts unsatisfied checks for its bit
module ecbf_cell import ecbf_pkg::*; (
  input  logic             clk,
  input  logic             clear,
  input  logic             inc,
  input  logic             shift,
  input  logic [CNT_W-1:0] cnt_in,
  output logic [CNT_W-1:0] cnt_out
);
  logic [CNT_W-1:0] cnt_r;

  // accumulate during count pass, pass to neighbor during scan
  always_ff @(posedge clk) begin
    if (clear) cnt_r <= '0;
    else if (shift) cnt_r <= cnt_in;
    else if (inc) cnt_r <= cnt_r + CNT_W'(1);
  end
  assign cnt_out = cnt_r;
endmodule

FILE: rtl/core/ecbf_row.sv
// row of counting cells shifting toward bit zero
module ecbf_row import ecbf_pkg::*; (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [MAX_BITS-1:0] inc_vec,
  output logic [CNT_W-1:0]    head_cnt
);
  logic [CNT_W-1:0] c [MAX_BITS+1];
  assign c[MAX_BITS] = '0;

  for (genvar j = 0; j < MAX_BITS; j++) begin : g_cell
    ecbf_cell u_cell (
      .clk(clk), .clear(ctl.clear), .inc(inc_vec[j] & ctl.parity_en),
      .shift(ctl.shift), .cnt_in(c[j+1]), .cnt_out(c[j])
    );
  end
  assign head_cnt = c[0];
endmodule
